// ===== sv/utt_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder package
// Shared constants, the job record passed from the front end to the byte
// serialiser, and the code point encoder.
// ----------------------------------------------------------------------------
package utt_pkg;

    // Bytes one request can produce: a replacement character plus a BMP one
    localparam int UTT_MAX_BYTES = 6;
    localparam int UTT_IDX_W     = 3;

    // Job queue between front end and serialiser
    localparam int UTT_FIFO_DEPTH = 2;
    localparam int UTT_PTR_W      = 1;
    localparam int UTT_CNT_W      = 2;

    // Code point width (up to U+10FFFF)
    localparam int UTT_CP_W = 21;

    // Surrogate ranges
    localparam logic [15:0] UTT_HIGH_FIRST = 16'hD800;
    localparam logic [15:0] UTT_HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] UTT_LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] UTT_LOW_LAST   = 16'hDFFF;

    // Supplementary plane base and encoding thresholds
    localparam logic [UTT_CP_W-1:0] UTT_SUPP_BASE = 21'h10000;
    localparam logic [UTT_CP_W-1:0] UTT_LIM_1B    = 21'h00080;
    localparam logic [UTT_CP_W-1:0] UTT_LIM_2B    = 21'h00800;

    // U+FFFD as UTF-8
    localparam logic [7:0] UTT_REPL_B0 = 8'hEF;
    localparam logic [7:0] UTT_REPL_B1 = 8'hBF;
    localparam logic [7:0] UTT_REPL_B2 = 8'hBD;

    // Lead and continuation byte prefixes
    localparam logic [1:0] UTT_CONT_PFX = 2'b10;
    localparam logic [2:0] UTT_LEAD2    = 3'b110;
    localparam logic [3:0] UTT_LEAD3    = 4'b1110;
    localparam logic [4:0] UTT_LEAD4    = 5'b11110;

    // Bytes of one encoded character, element 0 sent first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } utt_enc_t;

    // One request's worth of output bytes, element 0 sent first
    typedef struct packed {
        logic [UTT_MAX_BYTES-1:0][7:0] bytes;
        logic [UTT_IDX_W-1:0]          count;
        logic                          eos;
    } utt_job_t;

    // Encode one code point as 1 to 4 UTF-8 bytes
    function automatic utt_enc_t utt_encode(input logic [UTT_CP_W-1:0] cp);
        utt_enc_t enc;
        enc = '0;
        if (cp < UTT_LIM_1B) begin
            enc.bytes[0] = cp[7:0];
            enc.len      = 3'd1;
        end else if (cp < UTT_LIM_2B) begin
            enc.bytes[0] = {UTT_LEAD2, cp[10:6]};
            enc.bytes[1] = {UTT_CONT_PFX, cp[5:0]};
            enc.len      = 3'd2;
        end else if (cp < UTT_SUPP_BASE) begin
            enc.bytes[0] = {UTT_LEAD3, cp[15:12]};
            enc.bytes[1] = {UTT_CONT_PFX, cp[11:6]};
            enc.bytes[2] = {UTT_CONT_PFX, cp[5:0]};
            enc.len      = 3'd3;
        end else begin
            enc.bytes[0] = {UTT_LEAD4, cp[20:18]};
            enc.bytes[1] = {UTT_CONT_PFX, cp[17:12]};
            enc.bytes[2] = {UTT_CONT_PFX, cp[11:6]};
            enc.bytes[3] = {UTT_CONT_PFX, cp[5:0]};
            enc.len      = 3'd4;
        end
        return enc;
    endfunction

endpackage

// ===== sv/utt_front.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 front end
// Accepts code units, pairs surrogates and turns each request into a job of
// up to six UTF-8 bytes for the serialiser.
// ----------------------------------------------------------------------------
module utt_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [15:0]       s_code_unit,
    input  logic              s_end_of_string,
    output logic              push_valid,
    input  logic              push_ready,
    output utt_pkg::utt_job_t push_job
);
    import utt_pkg::*;

    logic                pending_reg, pending_next;
    logic [9:0]          high_bits_reg, high_bits_next;
    logic                accept;
    logic                is_high, is_low;
    logic                flush, alone, emit_main;
    logic [UTT_CP_W-1:0] main_cp;
    utt_enc_t            enc;
    utt_job_t            job;

    assign s_ready = push_ready;
    assign accept  = s_valid && s_ready;

    // Classify the incoming unit
    assign is_high = (s_code_unit >= UTT_HIGH_FIRST) && (s_code_unit <= UTT_HIGH_LAST);
    assign is_low  = (s_code_unit >= UTT_LOW_FIRST) && (s_code_unit <= UTT_LOW_LAST);

    // Pending high surrogate is either completed or flushed as U+FFFD
    assign flush     = pending_reg && !is_low;
    assign alone     = !(pending_reg && is_low);
    assign emit_main = !(alone && is_high && !s_end_of_string);

    // Pick the code point this unit completes
    always_comb begin
        if (!alone) begin
            main_cp = UTT_SUPP_BASE + {1'b0, high_bits_reg, s_code_unit[9:0]};
        end else if (is_high || is_low) begin
            main_cp = UTT_CP_W'(16'hFFFD);
        end else begin
            main_cp = UTT_CP_W'(s_code_unit);
        end
    end

    assign enc = utt_encode(main_cp);

    // Assemble the job: optional replacement first, then the main character
    always_comb begin
        job     = '0;
        job.eos = s_end_of_string;
        if (flush) begin
            job.bytes[0] = UTT_REPL_B0;
            job.bytes[1] = UTT_REPL_B1;
            job.bytes[2] = UTT_REPL_B2;
            if (emit_main) begin
                job.bytes[3] = enc.bytes[0];
                job.bytes[4] = enc.bytes[1];
                job.bytes[5] = enc.bytes[2];
                job.count    = 3'd3 + enc.len;
            end else begin
                job.count = 3'd3;
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                job.bytes[i] = enc.bytes[i];
            end
            job.count = enc.len;
        end
    end

    assign push_job   = job;
    assign push_valid = s_valid && (flush || emit_main);

    // Hold a high surrogate until its partner arrives
    always_comb begin
        pending_next   = pending_reg;
        high_bits_next = high_bits_reg;
        if (accept) begin
            pending_next   = alone && is_high && !s_end_of_string;
            high_bits_next = s_code_unit[9:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
        end
        high_bits_reg <= high_bits_next;
    end

`ifndef SYNTH
    a_eos_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_string) |=> !pending_reg)
        else $error("surrogate left pending after end of string");

    a_new_high_no_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_high && !pending_reg && !s_end_of_string) |-> !push_valid)
        else $error("output produced for a newly pending high surrogate");

    a_job_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (push_job.count != '0 && push_job.count <= 3'd6))
        else $error("job byte count out of range");
`endif

endmodule

// ===== sv/utt_fifo.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 job queue
// Short queue that decouples the front end from the byte serialiser.
// ----------------------------------------------------------------------------
module utt_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  utt_pkg::utt_job_t wr_job,
    output logic              rd_valid,
    input  logic              rd_ready,
    output utt_pkg::utt_job_t rd_job
);
    import utt_pkg::*;

    utt_job_t               entry_reg [UTT_FIFO_DEPTH];
    logic [UTT_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [UTT_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [UTT_CNT_W-1:0]   count_reg, count_next;
    logic                   do_wr, do_rd;

    assign wr_ready = (count_reg != UTT_CNT_W'(UTT_FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];

    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    // Advance pointers with wrap
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == UTT_PTR_W'(UTT_FIFO_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == UTT_PTR_W'(UTT_FIFO_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// ===== sv/utt_serial.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 byte serialiser
// Takes jobs from the queue and sends their bytes one per cycle, while m_ready
// allows, through a registered output stage.
// ----------------------------------------------------------------------------
module utt_serial (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  utt_pkg::utt_job_t pop_job,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_run_last,
    output logic              m_string_done
);
    import utt_pkg::*;

    logic                 busy_reg, busy_next;
    utt_job_t             job_reg, job_next;
    logic [UTT_IDX_W-1:0] idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_out_byte_reg, m_out_byte_next;
    logic                 m_run_last_reg, m_run_last_next;
    logic                 m_string_done_reg, m_string_done_next;

    logic                 out_free, have, load, fin;
    utt_job_t             src_job;
    logic [UTT_IDX_W-1:0] src_idx;

    // Output slot frees when empty or being taken
    assign out_free  = !m_valid_reg || m_ready;
    assign src_job   = busy_reg ? job_reg : pop_job;
    assign src_idx   = busy_reg ? idx_reg : '0;
    assign have      = busy_reg || pop_valid;
    assign load      = out_free && have;
    assign pop_ready = out_free && !busy_reg;
    assign fin       = (src_idx == src_job.count - 3'd1);

    // Advance through the current job, one byte per load
    always_comb begin
        busy_next          = busy_reg;
        job_next           = job_reg;
        idx_next           = idx_reg;
        m_valid_next       = m_valid_reg;
        m_out_byte_next    = m_out_byte_reg;
        m_run_last_next    = m_run_last_reg;
        m_string_done_next = m_string_done_reg;
        if (out_free) begin
            m_valid_next = have;
        end
        if (load) begin
            m_out_byte_next    = src_job.bytes[src_idx];
            m_run_last_next    = fin;
            m_string_done_next = fin && src_job.eos;
            job_next           = src_job;
            idx_next           = src_idx + 1'b1;
            busy_next          = !fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
        job_reg           <= job_next;
        idx_reg           <= idx_next;
        m_out_byte_reg    <= m_out_byte_next;
        m_run_last_reg    <= m_run_last_next;
        m_string_done_reg <= m_string_done_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_run_last    = m_run_last_reg;
    assign m_string_done = m_string_done_reg;

`ifndef SYNTH
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_string_done_reg) |-> m_run_last_reg)
        else $error("string end flagged on a byte that is not the last of its run");

    a_idx_in_job: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (idx_reg < job_reg.count))
        else $error("byte index ran past the job");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && !m_run_last_reg) |=> m_valid_reg)
        else $error("gap inside a run of bytes");
`endif

endmodule

// ===== sv/utf16_to_utf8_transcoder.sv =====
// A unit's job is registered in the queue before its bytes reach the output stage.
// The serialiser sends one UTF-8 byte per cycle while m_ready allows; a unit
// that only becomes pending produces no job and takes none of its time.
// A two-entry job queue lets input be taken while earlier bytes still drain.
// Reset (aresetn low, synchronous) clears the pending surrogate, queue and output.
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder
// Front end pairs surrogates and forms byte jobs; the serialiser emits bytes.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_code_unit,
    input  logic        s_end_of_string,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_run_last,
    output logic        m_string_done
);
    import utt_pkg::*;

    logic     push_valid, push_ready;
    utt_job_t push_job;
    logic     pop_valid, pop_ready;
    utt_job_t pop_job;

    // Classify and pair code units
    utt_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_code_unit     (s_code_unit),
        .s_end_of_string (s_end_of_string),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_job        (push_job)
    );

    // Buffer jobs between the two halves
    utt_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_job   (push_job),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_job   (pop_job)
    );

    // Send bytes one per cycle while m_ready allows
    utt_serial u_serial (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_job       (pop_job),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .m_string_done (m_string_done)
    );

endmodule
